// ----- rtl/core/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg
// shared types and constants of the stick calibration mapper
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

   // field widths
   localparam int SAMPLE_W = 12;
   localparam int CHAN_W   = 4;
   localparam int V12_W    = 13;
   localparam int V10_W    = 10;
   localparam int MID_CNT  = 4;
   localparam int MID_IDX_W = 2;
   localparam int QUO_W    = 12;
   localparam int STEP_W   = 4;

   // index of the last divider step: one compare step plus eleven shift steps
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

   // operation codes
   localparam logic OP_CONVERT = 1'b0;
   localparam logic OP_RESET   = 1'b1;

   // calibration constants
   localparam logic [SAMPLE_W-1:0] MID_RESET    = 12'd2048;
   localparam logic [SAMPLE_W-1:0] LOWER_RESET  = 12'd400;
   localparam logic [SAMPLE_W-1:0] UPPER_RESET  = 12'd3696;
   localparam logic [QUO_W-1:0]    QUO_MAX      = 12'd2048;
   localparam logic [V12_W-1:0]    CENTRE_OUT   = 13'd2048;
   localparam logic [V10_W-1:0]    V10_MAX      = 10'd1023;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic prep;
      logic step;
      logic load_out;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last_step;
   } status_type;

   // configuration write
   typedef struct packed {
      logic                 write;
      logic [MID_IDX_W-1:0] index;
      logic [SAMPLE_W-1:0]  data;
   } csr_write_type;

endpackage

`default_nettype wire

// ----- rtl/core/scm_ctrl.sv -----
// ----------------------------------------------------------------------------
// scm_ctrl
// sequencer: capture, bound update, serial divide, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module scm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire scm_pkg::status_type status,
   output scm_pkg::cmd_type        cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // output register can take a new result
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // commands decoded from state
   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.prep     = (state_ff == ST_PREP);
      cmd.step     = (state_ff == ST_DIV);
      cmd.load_out = (state_ff == ST_DONE) && out_free;
   end

   // state and result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (status.last_step) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/scm_datapath.sv -----
// ----------------------------------------------------------------------------
// scm_datapath
// mid registers, tracked bounds, restoring divider and result register
// ----------------------------------------------------------------------------
`default_nettype none

module scm_datapath #(
   parameter int STICK_CHANNELS = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire scm_pkg::cmd_type              cmd,
   output scm_pkg::status_type                status,
   input  wire scm_pkg::csr_write_type        csr,
   input  wire logic                          in_op,
   input  wire logic [scm_pkg::CHAN_W-1:0]    in_channel,
   input  wire logic [scm_pkg::SAMPLE_W-1:0]  in_raw,
   output logic [scm_pkg::V10_W-1:0]          out_v10,
   output logic [scm_pkg::V12_W-1:0]          out_v12,
   output logic                               out_zero_span
);

   localparam int IDX_W = (STICK_CHANNELS > 1) ? $clog2(STICK_CHANNELS) : 1;
   localparam int SW = scm_pkg::SAMPLE_W;
   localparam int QW = scm_pkg::QUO_W;

   logic [SW-1:0] mid_ff   [scm_pkg::MID_CNT];
   logic [SW-1:0] lower_ff [STICK_CHANNELS];
   logic [SW-1:0] upper_ff [STICK_CHANNELS];

   logic                      op_ff;
   logic [scm_pkg::CHAN_W-1:0] ch_ff;
   logic [SW-1:0]             raw_ff;
   logic                      below_ff;
   logic                      zero_ff;
   logic [SW-1:0]             span_ff;
   logic [SW-1:0]             rem_ff;
   logic [QW-1:0]             quo_ff;
   logic [scm_pkg::STEP_W-1:0] step_ff;

   logic                      stick;
   logic [IDX_W-1:0]          bidx;
   logic [SW-1:0]             mid;
   logic [SW-1:0]             lo_new;
   logic [SW-1:0]             hi_new;
   logic                      below;
   logic [SW-1:0]             num;
   logic [SW-1:0]             span;
   logic [SW:0]               trial;
   logic                      fits;
   logic [SW:0]               diff;
   logic [QW-1:0]             quo_sat;
   logic [scm_pkg::V12_W-1:0] v12;
   logic [scm_pkg::V10_W-1:0] v10;

   // channel decode and widened bounds
   assign stick  = (ch_ff < scm_pkg::CHAN_W'(STICK_CHANNELS));
   assign bidx   = ch_ff[IDX_W-1:0];
   assign mid    = mid_ff[ch_ff[scm_pkg::MID_IDX_W-1:0]];
   assign lo_new = (raw_ff < lower_ff[bidx]) ? raw_ff : lower_ff[bidx];
   assign hi_new = (raw_ff > upper_ff[bidx]) ? raw_ff : upper_ff[bidx];
   assign below  = (raw_ff < mid);
   assign num    = below ? (mid - raw_ff) : (raw_ff - mid);
   assign span   = below ? (mid - lo_new) : (hi_new - mid);

   // one restoring step: the first compares the offset itself, later ones shift
   assign trial = (step_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign fits  = (trial >= {1'b0, span_ff});
   assign diff  = trial - {1'b0, span_ff};

   assign status.last_step = (step_ff == scm_pkg::LAST_STEP);

   // result assembly
   assign quo_sat = (quo_ff > scm_pkg::QUO_MAX) ? scm_pkg::QUO_MAX : quo_ff;
   always_comb begin
      if (op_ff == scm_pkg::OP_RESET) begin
         v12 = '0;
      end else if (!stick) begin
         v12 = {1'b0, raw_ff};
      end else if (zero_ff) begin
         v12 = scm_pkg::CENTRE_OUT;
      end else if (below_ff) begin
         v12 = scm_pkg::CENTRE_OUT - {1'b0, quo_sat};
      end else begin
         v12 = scm_pkg::CENTRE_OUT + {1'b0, quo_sat};
      end
      if (op_ff == scm_pkg::OP_RESET) begin
         v10 = '0;
      end else if (v12[scm_pkg::V12_W-1]) begin
         v10 = scm_pkg::V10_MAX;
      end else begin
         v10 = v12[scm_pkg::V12_W-2:2];
      end
   end

   // mid point registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < scm_pkg::MID_CNT; i++) begin
            mid_ff[i] <= scm_pkg::MID_RESET;
         end
      end else if (csr.write) begin
         mid_ff[csr.index] <= csr.data;
      end
   end

   // tracked bounds per stick channel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STICK_CHANNELS; i++) begin
            lower_ff[i] <= scm_pkg::LOWER_RESET;
            upper_ff[i] <= scm_pkg::UPPER_RESET;
         end
      end else if (cmd.prep && stick) begin
         if (op_ff == scm_pkg::OP_RESET) begin
            lower_ff[bidx] <= scm_pkg::LOWER_RESET;
            upper_ff[bidx] <= scm_pkg::UPPER_RESET;
         end else begin
            lower_ff[bidx] <= lo_new;
            upper_ff[bidx] <= hi_new;
         end
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= in_op;
         ch_ff  <= in_channel;
         raw_ff <= in_raw;
      end
   end

   // divider setup and iteration
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         below_ff <= below;
         zero_ff  <= !below && (span == '0);
         span_ff  <= span;
         rem_ff   <= num;
         quo_ff   <= '0;
         step_ff  <= '0;
      end else if (cmd.step) begin
         rem_ff  <= fits ? diff[SW-1:0] : trial[SW-1:0];
         quo_ff  <= {quo_ff[QW-2:0], fits};
         step_ff <= step_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_v12       <= v12;
         out_v10       <= v10;
         out_zero_span <= (op_ff == scm_pkg::OP_CONVERT) && stick && zero_ff;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/stick_calibration_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// stick_calibration_mapper_unit
// three-point stick calibration with auto-ranging bounds
// ----------------------------------------------------------------------------
// A transaction on req_ carries an op, a channel number and a 12-bit sample.
// On a convert op, channels below STICK_CHANNELS widen their tracked bounds
// and are mapped about the channel's mid point onto 0..4096; other channels
// pass the sample. A reset op restores a stick channel's bounds and returns 0.
// Every request gives exactly one response transaction on rsp_.
// The csr_ channel writes the four mid registers (index 0..3); it is always
// ready and should only be used while no request is in flight.
// A request passes a bound-update state, 12 steps of the shared restoring
// divider and a hand-off state on its way to rsp_tvalid. One request is in
// work at a time; the next is accepted only once the block is back in idle.
// A finished result sits in the output register; while it waits the block
// takes and works on the next request, and only holds the hand-off of that
// one until rsp_tready frees the register.
// Reset (synchronous) sets all mid points to 2048 and all bounds to 400 and
// 3696, and drops any transaction in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_calibration_mapper_unit #(
   parameter int STICK_CHANNELS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] raw_sample, [15:12] zero
   input  wire logic [4:0]  req_tuser,   // [0] op, [4:1] channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [9:0] value_10bit, [22:10] value_12bit, [23] zero
   output logic             rsp_tuser,   // [0] zero_span
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data
);

   scm_pkg::cmd_type       cmd;
   scm_pkg::status_type    status;
   scm_pkg::csr_write_type csr;
   logic [scm_pkg::V10_W-1:0] v10;
   logic [scm_pkg::V12_W-1:0] v12;
   logic                      zero_span;

   // configuration writes are taken at once
   assign csr_ready = 1'b1;
   assign csr.write = csr_valid && csr_ready;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   // controller
   scm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   scm_datapath #(
      .STICK_CHANNELS (STICK_CHANNELS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr           (csr),
      .in_op         (req_tuser[0]),
      .in_channel    (req_tuser[4:1]),
      .in_raw        (req_tdata[11:0]),
      .out_v10       (v10),
      .out_v12       (v12),
      .out_zero_span (zero_span)
   );

   // response packing
   assign rsp_tdata = {1'b0, v12, v10};
   assign rsp_tuser = zero_span;

   // a zero span always reports the centre value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[22:10] == scm_pkg::CENTRE_OUT)
      else $error("zero span result is not centred");

   // the 10-bit value follows the 12-bit value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:0] == (rsp_tdata[22] ? scm_pkg::V10_MAX : rsp_tdata[21:12]))
      else $error("10-bit value inconsistent with 12-bit value");

   // mapped value never leaves 0..4096
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:10] <= 13'd4096)
      else $error("12-bit value out of range");

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

endmodule

`default_nettype wire
